>>> rtl/rttt_pkg.sv
// Shared types, constants and command/status structs for the repeating task timer table.
`timescale 1ns / 1ps
`default_nettype none

package rttt_pkg;

    localparam int SLOTS_DEF = 8;

    // At most this many slots fire on one tick; the rest wait for a later tick.
    localparam int MAX_FIRE = 8;
    localparam int FIRE_IW  = $clog2(MAX_FIRE);
    localparam int FIRE_CW  = FIRE_IW + 1;

    localparam logic [7:0]  REPEAT_FOREVER = 8'd10;
    localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_START  = 2'd1,
        KIND_CANCEL = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        RPL_FIRE   = 2'd0,
        RPL_START  = 2'd1,
        RPL_CANCEL = 2'd2
    } t_reply;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_REPLY,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [15:0] func;
        logic [31:0] arg;
        logic [15:0] interval;
        logic [7:0]  rep_cnt;
        logic [7:0]  fire_cnt;
        logic [15:0] elapsed;
    } t_slot;

    typedef struct packed {
        logic [2:0]  slot;
        logic [15:0] func;
        logic [31:0] arg;
    } t_fire;

    typedef struct packed {
        logic accept;
        logic walk_init;
        logic walk_step;
        logic reply_load;
        logic drain_load;
    } t_cmd;

    typedef struct packed {
        logic walk_done;
        logic fire_any;
        logic is_start;
        logic drain_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/rttt_if.sv
// Valid/ready channel interfaces for timer table requests and results.
`timescale 1ns / 1ps
`default_nettype none

interface rttt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] func_id;
    logic [31:0] task_arg;
    logic [15:0] interval;
    logic [7:0]  repeat_count;
    logic [3:0]  slot_id;

    modport source (
        output valid, kind, func_id, task_arg, interval, repeat_count, slot_id,
        input  ready
    );
    modport sink (
        input  valid, kind, func_id, task_arg, interval, repeat_count, slot_id,
        output ready
    );
endinterface

interface rttt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reply_kind;
    logic [2:0]  slot;
    logic [15:0] fired_func;
    logic [31:0] fired_arg;
    logic        status;
    logic        last;

    modport source (
        output valid, reply_kind, slot, fired_func, fired_arg, status, last,
        input  ready
    );
    modport sink (
        input  valid, reply_kind, slot, fired_func, fired_arg, status, last,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/rttt_ctrl.sv
// Controller state machine that sequences request intake, the slot walk and result delivery.
`timescale 1ns / 1ps
`default_nettype none

module rttt_ctrl import rttt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_kind,
    input  t_stat      i_stat,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_in_kind)
                        KIND_TICK, KIND_START: begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = ST_WALK;
                        end
                        KIND_CANCEL: begin
                            n_state = ST_REPLY;
                        end
                        default: begin
                            // An unused kind is dropped without a result.
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_done) begin
                    if (i_stat.is_start) begin
                        n_state = ST_REPLY;
                    end else if (i_stat.fire_any) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.reply_load = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (i_stat.out_free) begin
                    o_cmd.drain_load = 1'b1;
                    if (i_stat.drain_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/rttt_dp.sv
// Datapath: slot memory, valid bits, slot walk evaluation, fire buffer and output register.
`timescale 1ns / 1ps
`default_nettype none

module rttt_dp import rttt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_func_id,
    input  logic [31:0] i_task_arg,
    input  logic [15:0] i_interval,
    input  logic [7:0]  i_repeat_count,
    input  logic [3:0]  i_slot_id,
    input  logic        i_out_ready,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output logic [1:0]  o_reply_kind,
    output logic [2:0]  o_slot,
    output logic [15:0] o_fired_func,
    output logic [31:0] o_fired_arg,
    output logic        o_status,
    output logic        o_last
);

    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNTW = IDXW + 1;
    localparam int IDCW = ((IDXW > 4) ? IDXW : 4) + 1;

    // Captured request.
    logic [1:0]  r_kind;
    logic [15:0] r_func;
    logic [31:0] r_arg;
    logic [15:0] r_interval;
    logic [7:0]  r_rep;
    logic [3:0]  r_slot_id;

    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] n_valid;
    t_slot            r_mem [SLOTS];
    t_slot            r_rdata;

    logic [CNTW-1:0] r_iss;
    logic            r_ev_go;
    logic [IDXW-1:0] r_ev_idx;
    logic            r_found;
    logic [IDXW-1:0] r_found_idx;

    t_fire              r_fb [MAX_FIRE];
    logic [FIRE_CW-1:0] r_nfire;
    logic [FIRE_IW-1:0] r_dr;

    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [2:0]  r_out_slot;
    logic [15:0] r_out_func;
    logic [31:0] r_out_arg;
    logic        r_out_status;
    logic        r_out_last;

    logic            is_tick;
    logic            is_start;
    logic            ev_step;
    logic            ev_valid;
    logic [15:0]     el_inc;
    logic            due;
    logic            can_fire;
    logic            restart;
    logic            fire_push;
    logic            wr_en;
    t_slot           wr_data;
    logic [IDXW-1:0] rd_idx;
    logic [IDCW-1:0] id_ext;
    logic            id_ok;
    logic [IDXW-1:0] cancel_idx;
    logic            drain_last;
    logic            out_free;

    assign is_tick    = (r_kind == KIND_TICK);
    assign is_start   = (r_kind == KIND_START);
    assign ev_step    = i_cmd.walk_step && r_ev_go;
    assign ev_valid   = r_valid[r_ev_idx];
    assign el_inc     = (r_rdata.elapsed == ELAPSED_MAX) ? r_rdata.elapsed
                                                         : r_rdata.elapsed + 16'd1;
    assign due        = ev_valid && (el_inc >= r_rdata.interval);
    assign can_fire   = (r_nfire < FIRE_CW'(MAX_FIRE));
    // Forever repeat, or fewer firings so far than the count allows.
    assign restart    = (r_rdata.rep_cnt == REPEAT_FOREVER) ||
                        ((r_rdata.rep_cnt >= 8'd2) &&
                         (r_rdata.fire_cnt < (r_rdata.rep_cnt - 8'd1)));
    assign rd_idx     = (r_iss < CNTW'(SLOTS)) ? r_iss[IDXW-1:0] : '0;
    assign id_ext     = IDCW'(r_slot_id);
    assign id_ok      = (id_ext < IDCW'(SLOTS));
    assign cancel_idx = id_ext[IDXW-1:0];
    assign drain_last = ((FIRE_CW'(r_dr) + FIRE_CW'(1)) == r_nfire);
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_valid   = r_valid;
        wr_en     = 1'b0;
        wr_data   = r_rdata;
        fire_push = 1'b0;
        if (ev_step) begin
            if (is_tick) begin
                if (ev_valid) begin
                    wr_en           = 1'b1;
                    wr_data.elapsed = el_inc;
                    if (due && can_fire) begin
                        fire_push = 1'b1;
                        if (restart) begin
                            wr_data.fire_cnt = r_rdata.fire_cnt + 8'd1;
                            wr_data.elapsed  = '0;
                        end else begin
                            n_valid[r_ev_idx] = 1'b0;
                        end
                    end
                end
            end else if (!r_found && !ev_valid) begin
                // First free slot; a zero tag reports it but leaves it free.
                if (r_func != '0) begin
                    wr_en             = 1'b1;
                    wr_data.func      = r_func;
                    wr_data.arg       = r_arg;
                    wr_data.interval  = r_interval;
                    wr_data.rep_cnt   = r_rep;
                    wr_data.fire_cnt  = '0;
                    wr_data.elapsed   = '0;
                    n_valid[r_ev_idx] = 1'b1;
                end
            end else if (r_found && (r_func != '0) && ev_valid &&
                         (r_rdata.func == r_func)) begin
                n_valid[r_ev_idx] = 1'b0;
            end
        end
        if (i_cmd.reply_load && (r_kind == KIND_CANCEL) && id_ok) begin
            n_valid[cancel_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind     <= i_kind;
            r_func     <= i_func_id;
            r_arg      <= i_task_arg;
            r_interval <= i_interval;
            r_rep      <= i_repeat_count;
            r_slot_id  <= i_slot_id;
        end
    end

    // Slot memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_ev_idx] <= wr_data;
        end
        r_rdata <= r_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_iss   <= '0;
            r_ev_go <= 1'b0;
            r_found <= 1'b0;
            r_nfire <= '0;
            r_dr    <= '0;
        end else begin
            r_valid <= n_valid;
            if (i_cmd.walk_init) begin
                r_iss   <= '0;
                r_ev_go <= 1'b0;
                r_found <= 1'b0;
                r_nfire <= '0;
                r_dr    <= '0;
            end else begin
                if (i_cmd.walk_step) begin
                    if (r_iss < CNTW'(SLOTS)) begin
                        r_ev_go <= 1'b1;
                        r_iss   <= r_iss + CNTW'(1);
                    end else begin
                        r_ev_go <= 1'b0;
                    end
                end
                if (ev_step && is_start && !r_found && !ev_valid) begin
                    r_found <= 1'b1;
                end
                if (fire_push) begin
                    r_nfire <= r_nfire + FIRE_CW'(1);
                end
                if (i_cmd.drain_load) begin
                    r_dr <= r_dr + FIRE_IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step && (r_iss < CNTW'(SLOTS))) begin
            r_ev_idx <= r_iss[IDXW-1:0];
        end
        if (ev_step && is_start && !r_found && !ev_valid) begin
            r_found_idx <= r_ev_idx;
        end
        if (fire_push) begin
            r_fb[r_nfire[FIRE_IW-1:0]] <= '{slot: 3'(r_ev_idx),
                                            func: r_rdata.func,
                                            arg:  r_rdata.arg};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.reply_load || i_cmd.drain_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.reply_load) begin
            r_out_func <= '0;
            r_out_arg  <= '0;
            r_out_last <= 1'b1;
            if (r_kind == KIND_CANCEL) begin
                r_out_kind   <= RPL_CANCEL;
                r_out_slot   <= r_slot_id[2:0];
                r_out_status <= !id_ok;
            end else begin
                r_out_kind   <= RPL_START;
                r_out_slot   <= r_found ? 3'(r_found_idx) : '0;
                r_out_status <= !r_found;
            end
        end else if (i_cmd.drain_load) begin
            r_out_kind   <= RPL_FIRE;
            r_out_slot   <= r_fb[r_dr].slot;
            r_out_func   <= r_fb[r_dr].func;
            r_out_arg    <= r_fb[r_dr].arg;
            r_out_status <= 1'b0;
            r_out_last   <= drain_last;
        end
    end

    assign o_stat.walk_done  = (r_iss == CNTW'(SLOTS)) && !r_ev_go;
    assign o_stat.fire_any   = (r_nfire != '0);
    assign o_stat.is_start   = is_start;
    assign o_stat.drain_last = drain_last;
    assign o_stat.out_free   = out_free;

    assign o_out_valid  = r_out_valid;
    assign o_reply_kind = r_out_kind;
    assign o_slot       = r_out_slot;
    assign o_fired_func = r_out_func;
    assign o_fired_arg  = r_out_arg;
    assign o_status     = r_out_status;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire

>>> rtl/repeating_task_timer_table_top.sv
// Top level of the repeating task timer table: controller, datapath and channel hookup.
// Usage: requests enter on i_in (valid/ready), one beat per request. A tick advances all
// slot timers by one millisecond, a start takes the lowest free slot, a cancel frees one.
// Results leave on o_out (valid/ready): one beat per start or cancel, and one beat per
// slot that fires on a tick (at most eight per tick, in slot order, none on a quiet tick).
// The last field marks the final beat caused by a request.
// Sequence: a cancel result is loaded into the output register from the reply state
// once the register has room. A tick or a start walks the slot memory one slot per
// cycle through its single read port; then a start reply is loaded from the reply
// state, or the fire results of a tick from the fire buffer in the drain state, each
// while the output register has room. One request is in work at a time: the next one
// is taken only back in idle. Ready returns at the end of a quiet tick's walk, or when
// the last beat is in the output register, which holds it while the next is taken in.
// Reset: i_rst_n is synchronous and active low; it clears all slot valid bits together,
// so the table is empty with no clearing pass, and no beat is pending.
// Stall: while o_out.ready is low the pending beat holds and the controller waits to load
// the next beat; no result is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module repeating_task_timer_table_top import rttt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rttt_in_if.sink   i_in,
    rttt_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    rttt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_stat     (stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    rttt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (i_in.kind),
        .i_func_id      (i_in.func_id),
        .i_task_arg     (i_in.task_arg),
        .i_interval     (i_in.interval),
        .i_repeat_count (i_in.repeat_count),
        .i_slot_id      (i_in.slot_id),
        .i_out_ready    (o_out.ready),
        .o_stat         (stat),
        .o_out_valid    (o_out.valid),
        .o_reply_kind   (o_out.reply_kind),
        .o_slot         (o_out.slot),
        .o_fired_func   (o_out.fired_func),
        .o_fired_arg    (o_out.fired_arg),
        .o_status       (o_out.status),
        .o_last         (o_out.last)
    );

`ifndef SYNTHESIS
    // Start and cancel replies are always the only beat of their request.
    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.reply_kind == RPL_START || o_out.reply_kind == RPL_CANCEL))
        |-> o_out.last)
        else $error("start or cancel reply without last");

    // Fire beats never carry an error status.
    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.reply_kind == RPL_FIRE)) |-> !o_out.status)
        else $error("fire beat with error status");

    // A request that does work blocks intake on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready &&
         (i_in.kind == KIND_TICK || i_in.kind == KIND_START || i_in.kind == KIND_CANCEL))
        |=> !i_in.ready)
        else $error("request taken while another is in work");

    // Output loads happen only when the output register has room and never during intake.
    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.reply_load || cmd.drain_load) |-> (stat.out_free && !cmd.accept))
        else $error("output load without room or during intake");
`endif

endmodule

`default_nettype wire
